/* hw/rtl/qse_pkg.sv */
// Shared types and constants for the quicksort engine.
// Used by quicksort_engine_core, qse_range_stack and qse_checker.
package qse_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  // Smaller part is taken first, so the stack never holds more than log2(depth)+1 ranges.
  localparam int STACK_SLOTS = IDX_W + 1;
  localparam int SP_W        = $clog2(STACK_SLOTS + 1);
  localparam int SP_IDX_W    = $clog2(STACK_SLOTS);

  // Scan positions run from -1 to STORE_DEPTH.
  typedef logic signed [IDX_W+1:0] pos_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  typedef struct packed {
    logic   push_a;
    range_t range_a;
    logic   push_b;
    range_t range_b;
    logic   pop;
  } stk_ctl_t;

  typedef struct packed {
    logic   empty;
    range_t top;
  } stk_sts_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_POP,
    ST_PIVOT,
    ST_SCAN_I,
    ST_SCAN_J,
    ST_SWAP,
    ST_PUSH,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

/* hw/rtl/qse_range_stack.sv */
// Bounded stack of pending sort ranges, up to two pushes or one pop per cycle.
// Depends on qse_pkg.
module qse_range_stack import qse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  stk_ctl_t ctl,
  output stk_sts_t sts
);

  range_t          entry_r [STACK_SLOTS];
  logic [SP_W-1:0] sp_r, sp_nxt, sp_mid, sp_dec;
  logic            wr_a, wr_b;

  always_comb begin
    sp_dec = sp_r - 1'b1;
    wr_a   = ctl.push_a && (sp_r < SP_W'(STACK_SLOTS));
    sp_mid = wr_a ? sp_r + 1'b1 : sp_r;
    // drop a push onto a full stack
    wr_b   = ctl.push_b && (sp_mid < SP_W'(STACK_SLOTS));
    sp_nxt = sp_mid + SP_W'(wr_b);
    if (ctl.pop && (sp_r != '0)) begin
      sp_nxt = sp_dec;
    end
    sts.empty = (sp_r == '0);
    sts.top   = sts.empty ? '0 : entry_r[sp_dec[SP_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      entry_r[sp_r[SP_IDX_W-1:0]] <= ctl.range_a;
    end
    if (wr_b) begin
      entry_r[sp_mid[SP_IDX_W-1:0]] <= ctl.range_b;
    end
  end

endmodule

/* hw/rtl/quicksort_engine_core.sv */
// Load phase: one key per cycle. The request with end_of_set starts an in-place sort
// (Hoare partition, middle pivot) run over the key memory's single read and write port:
// compared keys, swaps and ranges each take steps of their own, roughly N log N steps in all.
// After the empty-stack check, ST_EMIT_RD and ST_EMIT_LD emit keys, one per cycle if out_ready.
// Synchronous reset clears count, overflow flag, stack pointer and control; no memory sweep.
module quicksort_engine_core import qse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [KEY_W-1:0] in_key_value,
  input  logic                    in_end_of_set,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [KEY_W-1:0] out_sorted_key,
  output logic                    out_final_key,
  output logic                    out_overflowed
);

  logic signed [KEY_W-1:0] mem [STORE_DEPTH];
  logic signed [KEY_W-1:0] rdata_r;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [IDX_W-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  pos_t                    i_r, i_nxt, j_r, j_nxt;
  logic signed [KEY_W-1:0] pivot_r, pivot_nxt, ki_r, ki_nxt;
  logic signed [KEY_W-1:0] out_key_r, out_key_nxt;
  logic                    out_final_r, out_final_nxt, out_ovf_r, out_ovf_nxt;
  logic                    out_valid_r, out_load;

  logic                    re, we;
  logic [IDX_W-1:0]        raddr, waddr;
  logic signed [KEY_W-1:0] wdata;
  logic [IDX_W:0]          mid_sum;
  pos_t                    lo_ext, hi_ext, i_inc, j_dec, size_l, size_r;
  logic                    has_l, has_r, is_final;

  stk_ctl_t stk_ctl;
  stk_sts_t stk_sts;

  qse_range_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .sts   (stk_sts)
  );

  assign in_ready       = (state_r == ST_LOAD);
  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_final_key  = out_final_r;
  assign out_overflowed = out_ovf_r;

  always_comb begin
    lo_ext   = pos_t'({2'b00, lo_r});
    hi_ext   = pos_t'({2'b00, hi_r});
    i_inc    = i_r + pos_t'(1);
    j_dec    = j_r - pos_t'(1);
    has_l    = lo_ext < j_r;
    has_r    = hi_ext > i_r;
    size_l   = j_r - lo_ext;
    size_r   = hi_ext - i_r;
    mid_sum  = {1'b0, stk_sts.top.lo} + {1'b0, stk_sts.top.hi};
    is_final = ((k_r + 1'b1) == count_r);

    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pivot_nxt     = pivot_r;
    ki_nxt        = ki_r;
    out_key_nxt   = out_key_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    out_load      = 1'b0;
    re            = 1'b0;
    raddr         = '0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = in_key_value;
    stk_ctl       = '0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (count_r < CNT_W'(STORE_DEPTH)) begin
            we        = 1'b1;
            waddr     = count_r[IDX_W-1:0];
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_end_of_set) begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        k_nxt = '0;
        if (count_r < CNT_W'(2)) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          stk_ctl.push_a     = 1'b1;
          stk_ctl.range_a.lo = '0;
          stk_ctl.range_a.hi = IDX_W'(count_r - 1'b1);
          state_nxt          = ST_POP;
        end
      end
      ST_POP: begin
        if (stk_sts.empty) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          stk_ctl.pop = 1'b1;
          lo_nxt      = stk_sts.top.lo;
          hi_nxt      = stk_sts.top.hi;
          re          = 1'b1;
          raddr       = mid_sum[IDX_W:1];
          state_nxt   = ST_PIVOT;
        end
      end
      ST_PIVOT: begin
        pivot_nxt = rdata_r;
        i_nxt     = lo_ext;
        j_nxt     = hi_ext;
        re        = 1'b1;
        raddr     = lo_r;
        state_nxt = ST_SCAN_I;
      end
      ST_SCAN_I: begin
        re = 1'b1;
        if ((i_r < hi_ext) && (rdata_r < pivot_r)) begin
          i_nxt = i_inc;
          raddr = i_inc[IDX_W-1:0];
        end else begin
          ki_nxt    = rdata_r;
          raddr     = j_r[IDX_W-1:0];
          state_nxt = ST_SCAN_J;
        end
      end
      ST_SCAN_J: begin
        if ((j_r > lo_ext) && (rdata_r > pivot_r)) begin
          j_nxt = j_dec;
          re    = 1'b1;
          raddr = j_dec[IDX_W-1:0];
        end else if (i_r <= j_r) begin
          // first half of the exchange: key at j goes to i
          we        = 1'b1;
          waddr     = i_r[IDX_W-1:0];
          wdata     = rdata_r;
          state_nxt = ST_SWAP;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_SWAP: begin
        we    = 1'b1;
        waddr = j_r[IDX_W-1:0];
        wdata = ki_r;
        i_nxt = i_inc;
        j_nxt = j_dec;
        if (i_inc < j_dec) begin
          re        = 1'b1;
          raddr     = i_inc[IDX_W-1:0];
          state_nxt = ST_SCAN_I;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_nxt = ST_POP;
        if (has_l && has_r) begin
          stk_ctl.push_a = 1'b1;
          stk_ctl.push_b = 1'b1;
          // push the larger part first
          if (size_l >= size_r) begin
            stk_ctl.range_a = '{lo: lo_r, hi: j_r[IDX_W-1:0]};
            stk_ctl.range_b = '{lo: i_r[IDX_W-1:0], hi: hi_r};
          end else begin
            stk_ctl.range_a = '{lo: i_r[IDX_W-1:0], hi: hi_r};
            stk_ctl.range_b = '{lo: lo_r, hi: j_r[IDX_W-1:0]};
          end
        end else if (has_l) begin
          stk_ctl.push_a  = 1'b1;
          stk_ctl.range_a = '{lo: lo_r, hi: j_r[IDX_W-1:0]};
        end else if (has_r) begin
          stk_ctl.push_a  = 1'b1;
          stk_ctl.range_a = '{lo: i_r[IDX_W-1:0], hi: hi_r};
        end
      end
      ST_EMIT_RD: begin
        re        = 1'b1;
        raddr     = k_r[IDX_W-1:0];
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        // hold the read data while the output register is still occupied
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_key_nxt   = rdata_r;
          out_final_nxt = is_final;
          out_ovf_nxt   = ovf_r;
          if (is_final) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt = k_r + 1'b1;
            re    = 1'b1;
            raddr = k_nxt[IDX_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_load | (out_valid_r & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    pivot_r     <= pivot_nxt;
    ki_r        <= ki_nxt;
    out_key_r   <= out_key_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/qse_checker.sv */
// Port-level checks for quicksort_engine_core, attached with a bind.
// Depends on qse_pkg.
module qse_checker import qse_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic signed [KEY_W-1:0] in_key_value,
  input logic                    in_end_of_set,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [KEY_W-1:0] out_sorted_key,
  input logic                    out_final_key,
  input logic                    out_overflowed
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_key)
      && $stable(out_final_key) && $stable(out_overflowed))
    else $error("stalled result changed");

  // no new request while a set is still being emitted
  a_no_load_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_key |-> !in_ready)
    else $error("input accepted during emission");

  // the end of a set closes the input
  a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_set |=> !in_ready)
    else $error("input still open after end of set");

  // overflow flag is constant over one set
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_key |=>
      !out_valid || (out_overflowed == $past(out_overflowed)))
    else $error("overflow flag changed within a set");

endmodule

bind quicksort_engine_core qse_checker u_qse_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for quicksort_engine_core: loads key sets over the request
// channel and checks every sorted key against an in-bench Hoare quicksort predictor.
// Depends on qse_pkg (hw/rtl/qse_pkg.sv) and the quicksort_engine_core RTL only.
module tb_top;
  import qse_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int ITEM_TARGET  = 250;
  localparam int CALM_FROM    = 215;
  localparam int HOLD_CYCLES  = 4000;
  localparam int TAIL_CYCLES  = 64;
  localparam int OPENING_ROWS = 22;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             ovf;
  } sorted_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             eos;
    logic             typed;
    logic [KEY_W-1:0] want_key;
    logic             want_last;
    logic             want_ovf;
  } opening_row_t;

  typedef enum int {KEYS_RANDOM, KEYS_NARROW, KEYS_EXTREME, KEYS_RISING, KEYS_FALLING} key_style_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [KEY_W-1:0] in_key_value = '0;
  logic                    in_end_of_set = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [KEY_W-1:0] out_sorted_key;
  logic                    out_final_key;
  logic                    out_overflowed;

  // Predictor state: shadow of the key store and the pending-range stack.
  logic signed [KEY_W-1:0] shadow_keys [STORE_DEPTH];
  int                      shadow_count = 0;
  bit                      shadow_ovf = 1'b0;
  range_t                  span_stack [STACK_SLOTS];
  int                      span_top = 0;
  sorted_t                 sorted_q [$];

  int  items_sent = 0;
  int  sets_done = 0;
  int  ovf_sets = 0;
  int  keys_checked = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  // Opening rows: single-key sets carry their expected result, the rest use the predictor.
  opening_row_t opening [OPENING_ROWS] = '{
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'hFFFF_FFF9, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'hFFFF_FFF9, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0000_0064, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0000_0032, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'hFFFF_FFCE, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'hFFFF_FF9C, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0}
  };

  quicksort_engine_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key_value   (in_key_value),
    .in_end_of_set  (in_end_of_set),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sorted_key (out_sorted_key),
    .out_final_key  (out_final_key),
    .out_overflowed (out_overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    fail_count++;
    $display("tb: mismatch on %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  function automatic void push_span(input int lo, input int hi);
    if (span_top >= STACK_SLOTS) return;
    span_stack[span_top].lo = IDX_W'(lo);
    span_stack[span_top].hi = IDX_W'(hi);
    span_top++;
  endfunction

  // Store one key; on the last key of a set, sort in place and queue every stored key.
  function automatic void load_key(input logic signed [KEY_W-1:0] key, input logic eos);
    int                      lo, hi, i, j;
    logic signed [KEY_W-1:0] pivot, tmp;
    sorted_t                 res;
    if (shadow_count < STORE_DEPTH) begin
      shadow_keys[shadow_count] = key;
      shadow_count++;
    end else begin
      shadow_ovf = 1'b1;
    end
    if (!eos) return;
    span_top = 0;
    if (shadow_count >= 2) push_span(0, shadow_count - 1);
    while (span_top > 0) begin
      span_top--;
      lo = span_stack[span_top].lo;
      hi = span_stack[span_top].hi;
      pivot = shadow_keys[(lo + hi) / 2];
      i = lo;
      j = hi;
      do begin
        while (i < hi && shadow_keys[i] < pivot) i++;
        while (j > lo && shadow_keys[j] > pivot) j--;
        if (i <= j) begin
          tmp = shadow_keys[i];
          shadow_keys[i] = shadow_keys[j];
          shadow_keys[j] = tmp;
          i++;
          j--;
        end
      end while (i < j);
      // push the larger part first so the smaller one is sorted next
      if (lo < j && hi > i) begin
        if (j - lo >= hi - i) begin
          push_span(lo, j);
          push_span(i, hi);
        end else begin
          push_span(i, hi);
          push_span(lo, j);
        end
      end else if (lo < j) begin
        push_span(lo, j);
      end else if (hi > i) begin
        push_span(i, hi);
      end
    end
    for (int k = 0; k < shadow_count; k++) begin
      res.key  = shadow_keys[k];
      res.last = (k == shadow_count - 1);
      res.ovf  = shadow_ovf;
      sorted_q.push_back(res);
    end
    sets_done++;
    if (shadow_ovf) ovf_sets++;
    shadow_count = 0;
    shadow_ovf = 1'b0;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input key_style_t style, input int k);
    case (style)
      KEYS_RANDOM: return $urandom;
      KEYS_NARROW: return $urandom_range(0, 8) - 4;
      KEYS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      KEYS_RISING: return k * 37 - 1000;
      default: return 1000 - k * 37;
    endcase
  endfunction

  // Offer one request, hold it until accepted, then update the predictor.
  task automatic send_key(input logic [KEY_W-1:0] key, input logic eos);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_key_value  <= key;
    in_end_of_set <= eos;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    load_key(key, eos);
  endtask

  initial begin : sink
    @(posedge clk);
    forever begin
      if (hold_req) begin
        // long hold-off: let the engine fill up and stall its input
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    sorted_t want;
    if (rst_n && out_valid && out_ready) begin
      keys_checked++;
      if (sorted_q.size() == 0) begin
        report_mismatch("unexpected sorted key", out_sorted_key, '0);
      end else begin
        want = sorted_q.pop_front();
        if (out_sorted_key !== want.key) report_mismatch("sorted_key", out_sorted_key, want.key);
        if (out_final_key !== want.last) begin
          report_mismatch("final_key", KEY_W'(out_final_key), KEY_W'(want.last));
        end
        if (out_overflowed !== want.ovf) begin
          report_mismatch("overflowed", KEY_W'(out_overflowed), KEY_W'(want.ovf));
        end
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("tb: timeout after %0d cycles, %0d sorted keys still due", cycle_count,
             sorted_q.size());
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int         len, sel, set_no;
    key_style_t style;
    sorted_t    typed_want;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[r]) begin
      send_key(opening[r].key, opening[r].eos);
      if (opening[r].typed) begin
        typed_want.key  = opening[r].want_key;
        typed_want.last = opening[r].want_last;
        typed_want.ovf  = opening[r].want_ovf;
        sorted_q[sorted_q.size() - 1] = typed_want;
      end
    end

    // Store full: the keys of the last two requests, the end-of-set one among them, are dropped.
    for (int k = 0; k < STORE_DEPTH + 2; k++) begin
      send_key(pick_key(KEYS_FALLING, k), k == STORE_DEPTH + 1);
    end

    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 19);
      if (sel < 13) len = $urandom_range(1, 16);
      else if (sel < 17) len = $urandom_range(17, STORE_DEPTH - 1);
      else if (sel == 17) len = STORE_DEPTH;
      else len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
      style = key_style_t'($urandom_range(0, 4));
      if (set_no == 0) hold_req = 1'b1;
      if (set_no < 2) len = STORE_DEPTH;
      if (set_no == 2) begin
        // drain everything before the next set
        in_valid <= 1'b0;
        @(posedge clk);
        while (sorted_q.size() != 0) @(posedge clk);
      end
      for (int k = 0; k < len; k++) begin
        calm = (items_sent >= CALM_FROM);
        send_key(pick_key(style, k), k == len - 1);
      end
      set_no++;
    end
    in_valid <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d keys sent in %0d sets (%0d with dropped keys), %0d sorted keys checked",
             items_sent, sets_done, ovf_sets, keys_checked);
    $display("tb: %0d mismatches in %0d cycles", fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
